### src/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;

   localparam int FIELD_W = 16;
   localparam int THR_W   = 9;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] VERDICT_KEPT     = 2'd0;
   localparam logic [1:0] VERDICT_SUPPRESS = 2'd1;
   localparam logic [1:0] VERDICT_OVER_IN  = 2'd2;
   localparam logic [1:0] VERDICT_FULL     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INPUTS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_KEEP      = 2'd2;

   localparam logic [THR_W-1:0]   THR_RESET       = 9'd179;
   localparam logic [FIELD_W-1:0] MAX_IN_RESET    = 16'd6000;
   localparam logic [THR_W-1:0]   MAX_KEEP_RESET  = 9'd256;

endpackage

### src/gbs_cell.sv
`timescale 1ns / 1ps
module gbs_cell #(
   parameter int COORD_BITS = 16,
   parameter int CNTW = 9,
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  logic [gbs_pkg::THR_W-1:0]     thr,
   input  logic [CNTW-1:0]               count,
   input  logic                          wr_en,
   input  logic [4*COORD_BITS-1:0]       wr_box,
   input  logic signed [2*COORD_BITS+1:0] wr_area,
   input  logic [4*COORD_BITS-1:0]       q_in,
   input  logic signed [2*COORD_BITS+1:0] a_in,
   input  logic                          h_in,
   output logic [4*COORD_BITS-1:0]       q_out,
   output logic signed [2*COORD_BITS+1:0] a_out,
   output logic                          h_out
);
   localparam int C  = COORD_BITS;
   localparam int AW = 2*C + 2;
   localparam int UW = 2*C + 14;

   logic [4*C-1:0]        box_ff;
   logic signed [AW-1:0]  area_ff;

   logic [4*C-1:0]        q1_ff, q2_ff;
   logic signed [AW-1:0]  a1_ff, a2_ff;
   logic                  h1_ff, h2_ff, v1_ff;
   logic signed [AW-1:0]  inter_ff, inter_in;
   logic signed [AW:0]    sum_ff, sum_in;

   logic [C-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   logic signed [C:0] ix, iy;
   logic disj, sup;
   logic signed [AW+1:0] un;
   logic signed [UW-1:0] lhs, rhs, thr_s;

   always_comb begin
      {ax1, ay1, ax2, ay2} = q_in;
      {bx1, by1, bx2, by2} = box_ff;
      disj = (ax1 > bx2) || (ax2 < bx1) || (ay1 > by2) || (ay2 < by1);
      ix = $signed({1'b0, (ax2 < bx2) ? ax2 : bx2}) - $signed({1'b0, (ax1 > bx1) ? ax1 : bx1});
      iy = $signed({1'b0, (ay2 < by2) ? ay2 : by2}) - $signed({1'b0, (ay1 > by1) ? ay1 : by1});
      inter_in = disj ? '0 : AW'(ix * iy);
      sum_in = (AW+1)'(a_in) + (AW+1)'(area_ff);
   end

   always_comb begin
      un    = (AW+2)'(sum_ff) - (AW+2)'(inter_ff);
      lhs   = UW'(inter_ff) <<< 8;
      thr_s = UW'($signed({1'b0, thr}));
      rhs   = thr_s * UW'(un);
      sup   = v1_ff && (un != '0) && (lhs > rhs);
   end

   always_ff @(posedge clock) begin
      if (wr_en && count == CNTW'(IDX)) begin
         box_ff  <= wr_box;
         area_ff <= wr_area;
      end
      q1_ff    <= q_in;
      a1_ff    <= a_in;
      h1_ff    <= h_in;
      v1_ff    <= (CNTW'(IDX) < count);
      inter_ff <= inter_in;
      sum_ff   <= sum_in;
      q2_ff    <= q1_ff;
      a2_ff    <= a1_ff;
      h2_ff    <= h1_ff | sup;
   end

   assign q_out = q2_ff;
   assign a_out = a2_ff;
   assign h_out = h2_ff;
endmodule

### src/greedy_box_suppression.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Direction  Handshake
// request   start, busy, req_left_x..req_set_end    in         start & !busy
// response  rsp_strobe, rsp_kept..rsp_set_done      out        strobe, one cycle
// csr       csr_we, csr_index, csr_wdata            in         write on csr_we
//
// From start to the response strobe, the box walks the whole chain of
// MAX_KEPT two-stage compare cells. An item past the input limit is answered
// without entering the chain.
// Reset clears counters and the controller; stored boxes are not cleared.
// The receiver cannot stall; busy holds off new items while one is in flight.
module greedy_box_suppression #(
   parameter int MAX_KEPT   = 256,
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [gbs_pkg::FIELD_W-1:0] req_left_x,
   input  logic [gbs_pkg::FIELD_W-1:0] req_top_y,
   input  logic [gbs_pkg::FIELD_W-1:0] req_right_x,
   input  logic [gbs_pkg::FIELD_W-1:0] req_bottom_y,
   input  logic req_set_end,
   output logic rsp_strobe,
   output logic rsp_kept,
   output logic [7:0] rsp_slot,
   output logic [1:0] rsp_verdict,
   output logic rsp_set_done,
   input  logic csr_we,
   input  logic [gbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbs_pkg::CSR_W-1:0] csr_wdata
);
   localparam int C    = COORD_BITS;
   localparam int AW   = 2*C + 2;
   localparam int CNTW = $clog2(MAX_KEPT + 1);
   localparam int RW   = $clog2(2*MAX_KEPT + 1);
   localparam logic [RW-1:0] RUN_LEN = RW'(2*MAX_KEPT);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type state_ff;
   logic [RW-1:0] run_ff;
   logic [CNTW-1:0] kept_count_ff;
   logic [gbs_pkg::FIELD_W-1:0] seen_ff;
   logic [gbs_pkg::THR_W-1:0] thr_ff, max_keep_ff;
   logic [gbs_pkg::FIELD_W-1:0] max_in_ff;

   logic [4*C-1:0] q_ff;
   logic signed [AW-1:0] area_ff;
   logic last_ff;

   logic strobe_ff, kept_ff, done_ff;
   logic [7:0] slot_ff;
   logic [1:0] verdict_ff;

   logic [C-1:0] lx, ty, rx, by;
   logic signed [C:0] dx, dy;
   logic accept, over_in, full, finish, wr_en;
   logic [gbs_pkg::FIELD_W-1:0] seen_in;

   logic [4*C-1:0]       q_ch [MAX_KEPT+1];
   logic signed [AW-1:0] a_ch [MAX_KEPT+1];
   logic                 h_ch [MAX_KEPT+1];

   // mask coordinates to the configured width
   assign lx = C'(req_left_x);
   assign ty = C'(req_top_y);
   assign rx = C'(req_right_x);
   assign by = C'(req_bottom_y);
   assign dx = $signed({1'b0, rx}) - $signed({1'b0, lx});
   assign dy = $signed({1'b0, by}) - $signed({1'b0, ty});

   assign accept  = start && !busy;
   assign over_in = (max_in_ff != '0) && (seen_ff >= max_in_ff);
   assign full    = (32'(kept_count_ff) >= 32'(max_keep_ff)) ||
                    (32'(kept_count_ff) >= 32'(MAX_KEPT));
   // the box has left the last cell once the run counter reaches its length
   assign finish  = (state_ff == ST_RUN) && (run_ff == RUN_LEN);
   assign wr_en   = finish && !h_ch[MAX_KEPT] && !full;
   assign seen_in = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   assign busy    = (state_ff != ST_IDLE);

   // cell zero sees the held box with no hit yet
   assign q_ch[0] = q_ff;
   assign a_ch[0] = area_ff;
   assign h_ch[0] = 1'b0;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      gbs_cell #(.COORD_BITS(C), .CNTW(CNTW), .IDX(i)) u_cell (
         .clock   (clock),
         .thr     (thr_ff),
         .count   (kept_count_ff),
         .wr_en   (wr_en),
         .wr_box  (q_ff),
         .wr_area (area_ff),
         .q_in    (q_ch[i]),
         .a_in    (a_ch[i]),
         .h_in    (h_ch[i]),
         .q_out   (q_ch[i+1]),
         .a_out   (a_ch[i+1]),
         .h_out   (h_ch[i+1])
      );
   end

   // latch the box and its area on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff    <= {lx, ty, rx, by};
         area_ff <= AW'(dx * dy);
         last_ff <= req_set_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_ff        <= '0;
         kept_count_ff <= '0;
         seen_ff       <= '0;
         thr_ff        <= gbs_pkg::THR_RESET;
         max_in_ff     <= gbs_pkg::MAX_IN_RESET;
         max_keep_ff   <= gbs_pkg::MAX_KEEP_RESET;
         strobe_ff     <= 1'b0;
         kept_ff       <= 1'b0;
         slot_ff       <= '0;
         verdict_ff    <= gbs_pkg::VERDICT_KEPT;
         done_ff       <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               gbs_pkg::CSR_IOU_THRESHOLD: thr_ff      <= csr_wdata[gbs_pkg::THR_W-1:0];
               gbs_pkg::CSR_MAX_INPUTS:    max_in_ff   <= csr_wdata;
               gbs_pkg::CSR_MAX_KEEP:      max_keep_ff <= csr_wdata[gbs_pkg::THR_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (over_in) begin
                     // answer at once, skip the chain
                     strobe_ff  <= 1'b1;
                     kept_ff    <= 1'b0;
                     slot_ff    <= '0;
                     verdict_ff <= gbs_pkg::VERDICT_OVER_IN;
                     done_ff    <= req_set_end;
                     if (req_set_end) begin
                        seen_ff       <= '0;
                        kept_count_ff <= '0;
                     end else begin
                        seen_ff <= seen_in;
                     end
                  end else begin
                     state_ff <= ST_RUN;
                     run_ff   <= '0;
                  end
               end
            end
            ST_RUN: begin
               run_ff <= run_ff + 1'b1;
               if (finish) begin
                  state_ff  <= ST_IDLE;
                  strobe_ff <= 1'b1;
                  done_ff   <= last_ff;
                  kept_ff   <= wr_en;
                  slot_ff   <= wr_en ? 8'(kept_count_ff) : 8'd0;
                  if (h_ch[MAX_KEPT]) begin
                     verdict_ff <= gbs_pkg::VERDICT_SUPPRESS;
                  end else if (full) begin
                     verdict_ff <= gbs_pkg::VERDICT_FULL;
                  end else begin
                     verdict_ff <= gbs_pkg::VERDICT_KEPT;
                  end
                  // close the set or advance the counters
                  if (last_ff) begin
                     seen_ff       <= '0;
                     kept_count_ff <= '0;
                  end else begin
                     seen_ff <= seen_in;
                     if (wr_en) begin
                        kept_count_ff <= kept_count_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_kept     = kept_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_verdict  = verdict_ff;
   assign rsp_set_done = done_ff;

   a_kept_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_kept == (rsp_verdict == gbs_pkg::VERDICT_KEPT)))
      else $error("kept flag disagrees with verdict");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_kept) |-> (rsp_slot == 8'd0))
      else $error("slot nonzero on a dropped item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(kept_count_ff) <= 32'(MAX_KEPT))
      else $error("kept count above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while an item is still in flight");
endmodule

### tb/sv/gbs_checker.sv
`timescale 1ns / 1ps
module gbs_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic [gbs_pkg::FIELD_W-1:0] req_left_x,
   input  logic [gbs_pkg::FIELD_W-1:0] req_top_y,
   input  logic [gbs_pkg::FIELD_W-1:0] req_right_x,
   input  logic [gbs_pkg::FIELD_W-1:0] req_bottom_y,
   input  logic req_set_end,
   input  logic rsp_strobe,
   input  logic rsp_kept,
   input  logic [7:0] rsp_slot,
   input  logic [1:0] rsp_verdict,
   input  logic rsp_set_done,
   input  logic csr_we,
   input  logic [gbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbs_pkg::CSR_W-1:0] csr_wdata,
   output int fail_count,
   output int pending,
   output int checked
);
   localparam int KEEP_DEPTH = 256;

   typedef struct packed {
      logic       kept;
      logic [7:0] slot;
      logic [1:0] verdict;
      logic       done;
   } outcome_type;

   outcome_type outcome_q[$];

   longint kx1[KEEP_DEPTH];
   longint ky1[KEEP_DEPTH];
   longint kx2[KEEP_DEPTH];
   longint ky2[KEEP_DEPTH];
   int unsigned kept_total;
   int unsigned seen_total;
   logic [gbs_pkg::THR_W-1:0] thr;
   logic [15:0] in_limit;
   logic [8:0] keep_limit;

   // Greedy IoU decision for one box, updating the kept list and counters.
   function automatic outcome_type judge_box(longint ax1, longint ay1, longint ax2,
                                             longint ay2, logic last);
      outcome_type o;
      longint area_a, area_b, inter, uni;
      int unsigned cap;
      bit hit;
      o = '0;
      o.done = last;
      hit = 0;
      cap = (keep_limit < KEEP_DEPTH) ? keep_limit : KEEP_DEPTH;
      area_a = (ax2 - ax1) * (ay2 - ay1);
      if (in_limit != 0 && seen_total >= in_limit) begin
         o.verdict = gbs_pkg::VERDICT_OVER_IN;
      end else begin
         for (int j = 0; j < kept_total; j++) begin
            if (ax1 > kx2[j] || ax2 < kx1[j] || ay1 > ky2[j] || ay2 < ky1[j])
               inter = 0;
            else
               inter = ((ax2 < kx2[j] ? ax2 : kx2[j]) - (ax1 > kx1[j] ? ax1 : kx1[j])) *
                       ((ay2 < ky2[j] ? ay2 : ky2[j]) - (ay1 > ky1[j] ? ay1 : ky1[j]));
            area_b = (kx2[j] - kx1[j]) * (ky2[j] - ky1[j]);
            uni = area_a + area_b - inter;
            if (uni != 0 && inter * 256 > longint'(thr) * uni) hit = 1;
         end
         if (hit) begin
            o.verdict = gbs_pkg::VERDICT_SUPPRESS;
         end else if (kept_total >= cap) begin
            o.verdict = gbs_pkg::VERDICT_FULL;
         end else begin
            o.verdict = gbs_pkg::VERDICT_KEPT;
            o.kept = 1'b1;
            o.slot = kept_total[7:0];
            kx1[kept_total] = ax1;
            ky1[kept_total] = ay1;
            kx2[kept_total] = ax2;
            ky2[kept_total] = ay2;
            kept_total++;
         end
      end
      if (seen_total < 65535) seen_total++;
      if (last) begin
         kept_total = 0;
         seen_total = 0;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         kept_total = 0;
         seen_total = 0;
         thr = gbs_pkg::THR_RESET;
         in_limit = gbs_pkg::MAX_IN_RESET;
         keep_limit = gbs_pkg::MAX_KEEP_RESET;
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               gbs_pkg::CSR_IOU_THRESHOLD: thr = csr_wdata[gbs_pkg::THR_W-1:0];
               gbs_pkg::CSR_MAX_INPUTS:    in_limit = csr_wdata;
               gbs_pkg::CSR_MAX_KEEP:      keep_limit = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (start && !busy)
            outcome_q.insert(outcome_q.size(),
                             judge_box(req_left_x, req_top_y, req_right_x,
                                       req_bottom_y, req_set_end));
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               $display("%0t unexpected response: expected none, got verdict %0d",
                        $time, rsp_verdict);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               checked++;
               if (rsp_kept !== want.kept) begin
                  $display("%0t kept: expected %0d, got %0d", $time, want.kept, rsp_kept);
                  fail_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $display("%0t slot: expected %0d, got %0d", $time, want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_verdict !== want.verdict) begin
                  $display("%0t verdict: expected %0d, got %0d", $time, want.verdict,
                           rsp_verdict);
                  fail_count++;
               end
               if (rsp_set_done !== want.done) begin
                  $display("%0t set_done: expected %0d, got %0d", $time, want.done,
                           rsp_set_done);
                  fail_count++;
               end
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   // Sender stalls aside, each box below the input limit walks the whole compare chain.
   localparam int ITEM_LATENCY = 2 * 256 + 2;
   localparam longint CYCLE_LIMIT = 4_000_000;
   // register index that maps to no register
   localparam logic [gbs_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [gbs_pkg::FIELD_W-1:0] req_left_x = '0;
   logic [gbs_pkg::FIELD_W-1:0] req_top_y = '0;
   logic [gbs_pkg::FIELD_W-1:0] req_right_x = '0;
   logic [gbs_pkg::FIELD_W-1:0] req_bottom_y = '0;
   logic req_set_end = 1'b0;
   logic rsp_strobe;
   logic rsp_kept;
   logic [7:0] rsp_slot;
   logic [1:0] rsp_verdict;
   logic rsp_set_done;
   logic csr_we = 1'b0;
   logic [gbs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gbs_pkg::CSR_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;
   longint cycles = 0;
   int boxes_sent = 0;
   int settings_run = 0;
   int burst_left = 0;

   // Center of the current cluster and the last box sent, for overlap shapes.
   int cx, cy;
   int px1, py1, px2, py2;

   greedy_box_suppression u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_left_x(req_left_x), .req_top_y(req_top_y),
      .req_right_x(req_right_x), .req_bottom_y(req_bottom_y),
      .req_set_end(req_set_end),
      .rsp_strobe(rsp_strobe), .rsp_kept(rsp_kept), .rsp_slot(rsp_slot),
      .rsp_verdict(rsp_verdict), .rsp_set_done(rsp_set_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   gbs_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_left_x(req_left_x), .req_top_y(req_top_y),
      .req_right_x(req_right_x), .req_bottom_y(req_bottom_y),
      .req_set_end(req_set_end),
      .rsp_strobe(rsp_strobe), .rsp_kept(rsp_kept), .rsp_slot(rsp_slot),
      .rsp_verdict(rsp_verdict), .rsp_set_done(rsp_set_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic int clamp16(int v);
      return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
   endfunction

   // Hold the box on the request ports until the block takes it, then
   // drop start only when the sender's burst runs out.
   task automatic send_box(int x1, int y1, int x2, int y2, bit last);
      req_left_x <= x1[15:0];
      req_top_y <= y1[15:0];
      req_right_x <= x2[15:0];
      req_bottom_y <= y2[15:0];
      req_set_end <= last;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      px1 = x1; py1 = y1; px2 = x2; py2 = y2;
      boxes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end
   endtask

   // Wait until every pending response has come back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [gbs_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(int thr_val, int in_val, int keep_val);
      drain();
      csr_write(gbs_pkg::CSR_IOU_THRESHOLD, thr_val);
      csr_write(gbs_pkg::CSR_MAX_INPUTS, in_val);
      csr_write(gbs_pkg::CSR_MAX_KEEP, keep_val);
      settings_run++;
   endtask

   // Mostly clusters of overlapping boxes around the set's center, with
   // random noise, degenerate, inverted, repeated and touching boxes mixed in.
   task automatic send_random_box(bit last);
      int kind, w, h, x1, y1;
      kind = $urandom_range(0, 9);
      w = $urandom_range(16, 4000);
      h = $urandom_range(16, 4000);
      x1 = cx + $urandom_range(0, 600) - 300 - w / 2;
      y1 = cy + $urandom_range(0, 600) - 300 - h / 2;
      case (kind)
         6: send_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), last);
         7: send_box(px1, py1, px2, py2, last);
         8: send_box(clamp16(x1 + w), clamp16(y1 + h), clamp16(x1), clamp16(y1), last);
         9: send_box(px2, py1, clamp16(px2 + w), py2, last);
         default: send_box(clamp16(x1), clamp16(y1), clamp16(x1 + w), clamp16(y1 + h), last);
      endcase
   endtask

   task automatic random_phase(int count, int set_max);
      int left;
      left = 0;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            left = $urandom_range(1, set_max);
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
         end
         left--;
         send_random_box(left == 0 || i == count - 1);
         if (i == count - 1) left = 0;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: full-range box, its duplicate, zero-size
      // boxes whose union is zero, inverted box, touching edges, set close.
      send_box(0, 0, 65535, 65535, 0);
      send_box(0, 0, 65535, 65535, 0);
      send_box(5, 5, 5, 5, 0);
      send_box(5, 5, 5, 5, 0);
      send_box(400, 400, 100, 100, 0);
      send_box(400, 400, 100, 100, 0);
      send_box(0, 0, 0, 0, 1);
      send_box(1000, 1000, 2000, 2000, 0);
      send_box(2000, 1000, 3000, 2000, 0);
      send_box(1100, 1100, 2100, 2100, 1);

      // Zero threshold: any positive overlap suppresses; stray index ignored.
      apply_setting(0, 0, 256);
      csr_write(CSR_UNUSED_IDX, 16'hFFFF);
      send_box(1000, 1000, 2000, 2000, 0);
      send_box(1999, 1999, 3000, 3000, 0);
      send_box(2000, 2000, 3000, 3000, 1);

      // Input limits of one and two, and keep limits of zero and one.
      apply_setting(256, 1, 0);
      send_box(10, 10, 20, 20, 0);
      send_box(10, 10, 20, 20, 1);
      apply_setting(511, 2, 1);
      send_box(10, 10, 20, 20, 0);
      send_box(10, 10, 20, 20, 0);
      send_box(50, 50, 60, 60, 1);
      apply_setting(179, 65535, 1);
      send_box(10, 10, 20, 20, 0);
      send_box(10, 10, 20, 20, 0);
      send_box(65535, 65535, 65535, 65535, 1);

      apply_setting(179, 6000, 256);
      random_phase(130, 12);
      apply_setting(0, 0, 256);
      random_phase(110, 10);
      apply_setting(256, 0, 256);
      random_phase(80, 10);
      apply_setting(511, 3, 256);
      random_phase(80, 8);
      apply_setting(128, 65535, 1);
      random_phase(100, 8);
      apply_setting(200, 0, 0);
      random_phase(50, 6);
      apply_setting(90, 1, 5);
      random_phase(80, 6);

      // Fill the whole kept list with disjoint tiles, then overflow it.
      apply_setting(179, 0, 256);
      for (int i = 0; i < 262; i++)
         send_box((i % 16) * 4000, (i / 16) * 4000, (i % 16) * 4000 + 1000,
                  (i / 16) * 4000 + 1000, i == 261);

      apply_setting(64, 0, 20);
      random_phase(150, 40);
      apply_setting(230, 6000, 256);
      random_phase(250, 15);

      drain();
      repeat (ITEM_LATENCY + 20) @(posedge clock);
      $display("sent %0d boxes over %0d register settings, %0d responses checked",
               boxes_sent, settings_run, checked);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
